// ----- sv/seb_pkg.sv -----
`default_nettype none

package seb_pkg;

	localparam int MAX_SEGMENTS_DEF = 32;
	localparam int COORD_BITS_DEF   = 12;

	localparam int          THRESH_W     = 16;
	localparam logic [15:0] THRESH_RESET = 16'd1440;
	localparam int          DIST_LIMIT   = 50000;

	// endpoint combination codes: bit 1 picks the stored end, bit 0 the new end
	localparam logic [1:0] PAIR_SS = 2'b00;
	localparam logic [1:0] PAIR_SE = 2'b01;
	localparam logic [1:0] PAIR_ES = 2'b10;
	localparam logic [1:0] PAIR_EE = 2'b11;

endpackage

`default_nettype wire

// ----- sv/seb_ram.sv -----
`default_nettype none

module seb_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/segment_endpoint_bridger_core.sv -----
`default_nettype none

// Segment endpoint bridger. Each accepted segment is compared with every
// segment stored in the current set, oldest first; for each stored segment
// the closest of the four endpoint pairs is found (first wins on a tie) and a
// bridge item from the stored endpoint to the new endpoint is sent out when
// its squared distance is below both distance_threshold and 50000. The last
// bridge caused by one segment carries last_of_run. new_set empties the store
// first; the store keeps up to MAX_SEGMENTS-1 segments, later ones are still
// compared but not kept. Each stored segment takes one memory read, four passes
// through the single shared squared-distance unit (two small multipliers
// followed by one add and compare), a drain state and a decision state; the
// decision and the final flush wait while a held bridge meets a stalled output.
// in_stall is high from acceptance until the block is idle again.
// distance_threshold is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while the block is idle, as the block does not enforce it.

module segment_endpoint_bridger_core #(
	parameter int MAX_SEGMENTS = seb_pkg::MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = seb_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_wr_en,
	input  wire logic [seb_pkg::THRESH_W-1:0]  cfg_wr_data,

	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire logic                          new_set,
	input  wire logic [COORD_BITS-1:0]         seg_x_start,
	input  wire logic [COORD_BITS-1:0]         seg_y_start,
	input  wire logic [COORD_BITS-1:0]         seg_x_end,
	input  wire logic [COORD_BITS-1:0]         seg_y_end,

	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      logic [COORD_BITS-1:0]         bridge_x_from,
	output      logic [COORD_BITS-1:0]         bridge_y_from,
	output      logic [COORD_BITS-1:0]         bridge_x_to,
	output      logic [COORD_BITS-1:0]         bridge_y_to,
	output      logic                          last_of_run
);

	import seb_pkg::*;

	localparam int CW    = COORD_BITS;
	localparam int IW    = $clog2(MAX_SEGMENTS);
	localparam int SW    = 4 * CW;
	localparam int SQW   = 2 * CW;
	localparam int DW    = (2 * CW + 1 > 17) ? 2 * CW + 1 : 17;
	localparam logic [IW-1:0] CAP   = IW'(MAX_SEGMENTS - 1);
	localparam logic [DW-1:0] LIMIT = DW'(DIST_LIMIT);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_RD    = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_FIN   = 7'b0001000,
		ST_DEC   = 7'b0010000,
		ST_FLUSH = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [CW-1:0] x_from;
		logic [CW-1:0] y_from;
		logic [CW-1:0] x_to;
		logic [CW-1:0] y_to;
	} bridge_t;

	state_t state_q, state_d;

	logic [THRESH_W-1:0] thresh_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       n_q;
	logic [IW-1:0]       idx_q;
	logic [1:0]          k_q;
	logic [SW-1:0]       new_q;

	logic [SW-1:0]       rd_data;
	logic [SQW-1:0]      sqx_s1, sqy_s1;
	logic [1:0]          k_s1;
	logic                v_s1;
	logic [DW-1:0]       best_q;
	logic [1:0]          pick_q;
	logic                found_q;

	bridge_t             pend_q, cand;
	logic                pend_v_q;
	bridge_t             out_q;
	logic                out_v_q, out_last_q;

	logic                in_acc;
	logic [IW-1:0]       eff_cnt;
	logic                room;
	logic [CW-1:0]       sx, sy, nx, ny, dx, dy;
	logic [DW-1:0]       dsum;
	logic                bridge_hit, out_free, push, push_last;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign eff_cnt  = new_set ? '0 : cnt_q;
	assign room     = (eff_cnt < CAP);

	seb_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_SEGMENTS)
	) u_store (
		.clk  (clk),
		.we   (in_acc && room),
		.waddr(eff_cnt),
		.wdata({seg_x_start, seg_y_start, seg_x_end, seg_y_end}),
		.re   (state_q == ST_RD),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	// shared squared-distance unit, one endpoint pair per cycle
	always_comb begin
		sx = k_q[1] ? rd_data[CW+:CW]     : rd_data[3*CW+:CW];
		sy = k_q[1] ? rd_data[0+:CW]      : rd_data[2*CW+:CW];
		nx = k_q[0] ? new_q[CW+:CW]       : new_q[3*CW+:CW];
		ny = k_q[0] ? new_q[0+:CW]        : new_q[2*CW+:CW];
		dx = (sx > nx) ? sx - nx : nx - sx;
		dy = (sy > ny) ? sy - ny : ny - sy;
	end

	assign dsum = DW'(sqx_s1) + DW'(sqy_s1);

	always_comb begin
		cand.x_from = pick_q[1] ? rd_data[CW+:CW] : rd_data[3*CW+:CW];
		cand.y_from = pick_q[1] ? rd_data[0+:CW]  : rd_data[2*CW+:CW];
		cand.x_to   = pick_q[0] ? new_q[CW+:CW]   : new_q[3*CW+:CW];
		cand.y_to   = pick_q[0] ? new_q[0+:CW]    : new_q[2*CW+:CW];
	end

	assign bridge_hit = found_q && (best_q < DW'(thresh_q));
	assign out_free   = !out_v_q || !out_stall;
	assign push       = pend_v_q && out_free &&
	                    ((state_q == ST_DEC && bridge_hit) || state_q == ST_FLUSH);
	assign push_last  = (state_q == ST_FLUSH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (eff_cnt == '0) ? ST_FLUSH : ST_RD;
				end
			end
			ST_RD:  state_d = ST_MUL;
			ST_MUL: begin
				if (k_q == PAIR_EE) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_DEC;
			ST_DEC: begin
				if (!(bridge_hit && pend_v_q && !out_free)) begin
					state_d = (idx_q == n_q - 1'b1) ? ST_FLUSH : ST_RD;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			thresh_q   <= THRESH_RESET;
			cnt_q      <= '0;
			n_q        <= '0;
			idx_q      <= '0;
			k_q        <= PAIR_SS;
			v_s1       <= 1'b0;
			found_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
			if (in_acc) begin
				cnt_q <= room ? eff_cnt + 1'b1 : eff_cnt;
				n_q   <= eff_cnt;
				idx_q <= '0;
			end
			if (state_q == ST_RD) begin
				k_q <= PAIR_SS;
			end else if (state_q == ST_MUL) begin
				k_q <= k_q + 1'b1;
			end
			v_s1 <= (state_q == ST_MUL);
			if (state_q == ST_RD) begin
				found_q <= 1'b0;
			end else if (v_s1 && dsum < best_q) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_DEC && state_d != ST_DEC) begin
				idx_q <= idx_q + 1'b1;
				if (bridge_hit) begin
					pend_v_q <= 1'b1;
				end
			end
			if (state_q == ST_FLUSH && push) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_v_q    <= 1'b1;
				out_last_q <= push_last;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			new_q <= {seg_x_start, seg_y_start, seg_x_end, seg_y_end};
		end
		if (state_q == ST_MUL) begin
			sqx_s1 <= SQW'(dx * dx);
			sqy_s1 <= SQW'(dy * dy);
			k_s1   <= k_q;
		end
		if (state_q == ST_RD) begin
			best_q <= LIMIT;
		end else if (v_s1 && dsum < best_q) begin
			best_q <= dsum;
			pick_q <= k_s1;
		end
		if (state_q == ST_DEC && state_d != ST_DEC && bridge_hit) begin
			pend_q <= cand;
		end
		if (push) begin
			out_q <= pend_q;
		end
	end

	assign out_valid     = out_v_q;
	assign bridge_x_from = out_q.x_from;
	assign bridge_y_from = out_q.y_from;
	assign bridge_x_to   = out_q.x_to;
	assign bridge_y_to   = out_q.y_to;
	assign last_of_run   = out_last_q;

	// store never grows past its capacity
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CAP)
		else $error("stored count beyond capacity");

	// every read addresses a segment of the current set
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> idx_q < n_q)
		else $error("read beyond stored segments");

	// a held bridge is always flushed before the next item is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("bridge left pending while idle");

	// each read is followed by the four distance passes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |=> state_q == ST_MUL && k_q == PAIR_SS)
		else $error("distance passes not started after read");

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import seb_pkg::*;

	localparam int CB            = COORD_BITS_DEF;
	localparam int MAXS          = MAX_SEGMENTS_DEF;
	localparam int COORD_MAX     = (1 << CB) - 1;
	localparam int SETTLE_CYCLES = 2 + 7 * (MAXS - 1) + 16;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 46;
	localparam int N_DIR         = 19;

	localparam logic [1:0] PAIR_ORDER [4] = '{PAIR_SS, PAIR_SE, PAIR_ES, PAIR_EE};

	typedef struct packed {
		logic [CB-1:0] xs, ys, xe, ye;
	} seg_t;

	typedef struct packed {
		logic [CB-1:0] xf, yf, xt, yt;
		logic          last;
	} bridge_t;

	typedef enum bit {ROW_SEG, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [THRESH_W-1:0]   thr;
		bit                    ns;
		seg_t                  seg;
		bit                    typed;
		bit                    has_bridge;
		bridge_t               bridge;
	} row_t;

	// typed rows carry the bridge they must produce, the rest go through the predictor
	row_t dir_tab [N_DIR] = '{
		'{ROW_SEG, 0,     1, '{0, 0, 4095, 4095},       1, 0, '0},
		'{ROW_SEG, 0,     0, '{4095, 4095, 0, 0},       1, 1, '{0, 0, 0, 0, 1}},
		'{ROW_SEG, 0,     1, '{10, 10, 100, 10},        1, 0, '0},
		'{ROW_SEG, 0,     0, '{100, 20, 200, 20},       1, 1, '{100, 10, 100, 20, 1}},
		'{ROW_SEG, 0,     0, '{3000, 3000, 3500, 3500}, 1, 0, '0},
		'{ROW_SEG, 0,     0, '{130, 20, 3000, 3030},    0, 0, '0},
		'{ROW_SEG, 0,     1, '{500, 500, 510, 500},     1, 0, '0},
		'{ROW_SEG, 0,     0, '{546, 512, 3000, 100},    1, 0, '0},
		'{ROW_SEG, 0,     0, '{545, 512, 2000, 2000},   0, 0, '0},
		'{ROW_CFG, 0,     0, '0,                        0, 0, '0},
		'{ROW_SEG, 0,     0, '{510, 500, 546, 512},     1, 0, '0},
		'{ROW_CFG, 65535, 0, '0,                        0, 0, '0},
		'{ROW_SEG, 0,     1, '{0, 0, 0, 0},             1, 0, '0},
		'{ROW_SEG, 0,     0, '{223, 0, 4095, 4095},     1, 1, '{0, 0, 223, 0, 1}},
		'{ROW_SEG, 0,     0, '{0, 224, 4095, 0},        1, 0, '0},
		'{ROW_CFG, 50000, 0, '0,                        0, 0, '0},
		'{ROW_SEG, 0,     0, '{4095, 4095, 4095, 4095}, 1, 1, '{4095, 4095, 4095, 4095, 1}},
		'{ROW_SEG, 0,     0, '{4095, 3900, 4000, 0},    0, 0, '0},
		'{ROW_CFG, 1440,  0, '0,                        0, 0, '0}
	};

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cfg_wr_en   = 1'b0;
	logic [THRESH_W-1:0] cfg_wr_data = '0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic                new_set     = 1'b0;
	logic [CB-1:0]       seg_x_start = '0;
	logic [CB-1:0]       seg_y_start = '0;
	logic [CB-1:0]       seg_x_end   = '0;
	logic [CB-1:0]       seg_y_end   = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [CB-1:0]       bridge_x_from;
	logic [CB-1:0]       bridge_y_from;
	logic [CB-1:0]       bridge_x_to;
	logic [CB-1:0]       bridge_y_to;
	logic                last_of_run;

	// table row of the item on the bus, -1 for random items
	int row_tag = -1;

	// predictor state
	seg_t                seg_mem [MAXS];
	int                  seg_count    = 0;
	logic [THRESH_W-1:0] thresh_model = THRESH_RESET;
	bridge_t             fresh [$];
	bridge_t             bridges_due [$];

	int errors        = 0;
	int items_taken   = 0;
	int bridges_seen  = 0;
	int thr_writes    = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asks     = 0;
	int hold_served   = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	segment_endpoint_bridger_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.new_set       (new_set),
		.seg_x_start   (seg_x_start),
		.seg_y_start   (seg_y_start),
		.seg_x_end     (seg_x_end),
		.seg_y_end     (seg_y_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.bridge_x_from (bridge_x_from),
		.bridge_y_from (bridge_y_from),
		.bridge_x_to   (bridge_x_to),
		.bridge_y_to   (bridge_y_to),
		.last_of_run   (last_of_run)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// bridges caused by one segment, left in fresh; also updates the store
	function automatic void predict_bridges(input bit clear, input seg_t s);
		seg_t          old;
		logic [CB-1:0] fx, fy, tx, ty, bfx, bfy, btx, bty;
		int unsigned   dx, dy, d, best;
		bit            hit;
		fresh.delete();
		if (clear)
			seg_count = 0;
		for (int i = 0; i < seg_count; i++) begin
			old  = seg_mem[i];
			best = DIST_LIMIT;
			hit  = 1'b0;
			bfx = '0; bfy = '0; btx = '0; bty = '0;
			for (int k = 0; k < 4; k++) begin
				fx = PAIR_ORDER[k][1] ? old.xe : old.xs;
				fy = PAIR_ORDER[k][1] ? old.ye : old.ys;
				tx = PAIR_ORDER[k][0] ? s.xe : s.xs;
				ty = PAIR_ORDER[k][0] ? s.ye : s.ys;
				dx = (fx > tx) ? fx - tx : tx - fx;
				dy = (fy > ty) ? fy - ty : ty - fy;
				d  = dx * dx + dy * dy;
				// strict compare keeps the first pair on a tie
				if (d < best) begin
					best = d;
					hit  = 1'b1;
					bfx = fx; bfy = fy; btx = tx; bty = ty;
				end
			end
			if (hit && best < thresh_model)
				fresh.insert(fresh.size(), bridge_t'{bfx, bfy, btx, bty, 1'b0});
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		// full store: compared but not kept
		if (seg_count < MAXS - 1) begin
			seg_mem[seg_count] = s;
			seg_count++;
		end
	endfunction

	function automatic void report_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [CB-1:0] near(input int c, input int spread);
		int v;
		v = c + int'($urandom_range(2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[CB-1:0];
	endfunction

	always @(posedge clk) begin : monitor
		bridge_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_bridges(new_set, '{seg_x_start, seg_y_start, seg_x_end, seg_y_end});
				if (row_tag >= 0 && dir_tab[row_tag].typed) begin
					if (dir_tab[row_tag].has_bridge)
						bridges_due.insert(bridges_due.size(), dir_tab[row_tag].bridge);
				end else begin
					foreach (fresh[j])
						bridges_due.insert(bridges_due.size(), fresh[j]);
				end
				items_taken++;
			end
			if (out_valid && !out_stall) begin
				bridges_seen++;
				if (bridges_due.size() == 0) begin
					$display("%0t unexpected bridge: expected none, actual %0d,%0d -> %0d,%0d",
						$time, bridge_x_from, bridge_y_from, bridge_x_to, bridge_y_to);
					errors++;
				end else begin
					want = bridges_due.pop_front();
					report_field("bridge_x_from", want.xf, bridge_x_from);
					report_field("bridge_y_from", want.yf, bridge_y_from);
					report_field("bridge_x_to", want.xt, bridge_x_to);
					report_field("bridge_y_to", want.yt, bridge_y_to);
					report_field("last_of_run", want.last, last_of_run);
				end
			end
		end
	end

	// output side: random stall, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no progress for %0d cycles, %0d bridges outstanding",
				$time, QUIET_LIMIT, bridges_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_seg(input bit clear, input seg_t s, input int tag);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		new_set     <= clear;
		seg_x_start <= s.xs;
		seg_y_start <= s.ys;
		seg_x_end   <= s.xe;
		seg_y_end   <= s.ye;
		row_tag     <= tag;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bridges_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_threshold(input logic [THRESH_W-1:0] value);
		drain();
		// a segment with no bridges may still be in progress
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		thresh_model = value;
		thr_writes++;
	endtask

	initial begin : stimulus
		int   sent;
		int   set_len;
		int   cx, cy, spread;
		bit   long_done;
		bit   paused;
		seg_t s;

		long_done = 1'b0;
		paused    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 20;
		recv_stall_pct = 74;
		foreach (dir_tab[r]) begin
			if (dir_tab[r].kind == ROW_CFG)
				write_threshold(dir_tab[r].thr);
			else
				send_seg(dir_tab[r].ns, dir_tab[r].seg, r);
		end

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_idle_pct  = 20;
					recv_stall_pct = 74;
					write_threshold(16'($urandom_range(20000, 50000)));
				end
				1: begin
					send_idle_pct  = 74;
					recv_stall_pct = 20;
					write_threshold(16'hFFFF);
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
					write_threshold(16'($urandom_range(1000, 50000)));
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(7) == 0) begin
					// noise: anywhere, with a random set flag
					s = '{CB'($urandom_range(COORD_MAX)), CB'($urandom_range(COORD_MAX)),
						CB'($urandom_range(COORD_MAX)), CB'($urandom_range(COORD_MAX))};
					send_seg(1'($urandom_range(1)), s, -1);
					sent++;
				end else begin
					// a set of segments clustered around one point
					if (p == 1 && !long_done) begin
						set_len   = MAXS + 4;
						long_done = 1'b1;
					end else begin
						set_len = $urandom_range(2, 8);
					end
					if (p == 0 && sent >= 12 && hold_asks == 0)
						hold_asks++;
					cx     = $urandom_range(COORD_MAX);
					cy     = $urandom_range(COORD_MAX);
					spread = 40 * $urandom_range(1, 4);
					for (int j = 0; j < set_len; j++) begin
						s.xs = near(cx, spread);
						s.ys = near(cy, spread);
						s.xe = near(cx + int'($urandom_range(600)) - 300, spread);
						s.ye = near(cy + int'($urandom_range(600)) - 300, spread);
						send_seg(j == 0, s, -1);
						sent++;
					end
				end
				if (p == 1 && sent >= 30 && !paused) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("segments taken: %0d, bridges checked: %0d, threshold writes: %0d",
			items_taken, bridges_seen, thr_writes);
		$display("covered ties, threshold edge, distance bound, store overflow, output hold-off");
		if (errors == 0 && bridges_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d bridges never seen", errors, bridges_due.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/seb_pkg.sv
sv/seb_ram.sv
sv/segment_endpoint_bridger_core.sv
verif/testbench.sv
